/* hdl/cws_pkg.sv */
// ----------------------------------------------------------------------------
// cws_pkg
// Types and character constants for the comment and whitespace stripper.
// ----------------------------------------------------------------------------
package cws_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // Results one item can produce: separator, held byte, and one more.
    localparam int RES_SLOTS = 3;

    typedef enum logic [3:0] {
        MODE_TOK        = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_LINE       = 4'd2,
        MODE_BLOCK      = 4'd3,
        MODE_BLOCK_STAR = 4'd4,
        MODE_QUOTE      = 4'd5,
        MODE_BSL        = 4'd6,
        MODE_BSL_CR     = 4'd7,
        MODE_WORD       = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        SEP_NONE    = 2'd0,
        SEP_SPACE   = 2'd1,
        SEP_NEWLINE = 2'd2
    } t_sep;

    // What one token-level byte does: new mode and separator, whether the
    // old separator is emitted first, and whether the byte itself is copied.
    typedef struct packed {
        t_mode mode;
        t_sep  sep;
        logic  flush;
        logic  put;
    } t_act;

endpackage

/* hdl/comment_whitespace_stripper.sv */
// ----------------------------------------------------------------------------
// comment_whitespace_stripper
// Removes comments and collapses whitespace in a byte stream of C-like text.
// ----------------------------------------------------------------------------
// The block takes one text byte per item and decides it in the cycle it is
// accepted. It writes the zero to three result items that the byte causes
// into a small result register. They leave one per cycle while i_stall is
// low, starting the cycle after the byte is taken. An input item whose
// results are one or none is followed by the next in the following cycle
// when the output is not stalled, so ordinary text then streams at one byte
// per cycle. Some bytes have two or three results: a byte that releases held
// lookahead (a slash or backslash that turned out not to start a comment or
// a line splice, or the end of string), and a token byte that first emits a
// pending separator. Such a byte occupies the result register until its last
// result leaves, and the input stalls until that last result is taken. A zero
// byte ends the string, gives one end item carrying the saturating output
// count, and returns the block to its reset state.
module comment_whitespace_stripper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_end,
    output logic [15:0] o_out_count
);
    import cws_pkg::*;

    // Scan state.
    t_mode       r_mode, n_mode;
    t_sep        r_sep,  n_sep;
    logic [15:0] r_cnt,  n_cnt;

    // Result register: up to three results of the last accepted item.
    logic [7:0]  r_byte [RES_SLOTS];
    logic [7:0]  n_byte [RES_SLOTS];
    logic [1:0]  r_num,  n_num;
    logic [1:0]  r_idx;
    logic        r_end,  n_end;
    logic [15:0] r_gcnt;

    logic        in_acc, out_acc, free;
    logic [1:0]  k, nb;
    logic [16:0] sum;
    t_act        act;

    function automatic t_act tok_step(input t_sep s, input logic [7:0] c);
        t_act a;
        a.mode  = MODE_TOK;
        a.sep   = s;
        a.flush = 1'b0;
        a.put   = 1'b0;
        if (c <= CH_SPACE) begin
            if (c == CH_LF) begin
                a.sep = SEP_NEWLINE;
            end else if (s == SEP_NONE) begin
                a.sep = SEP_SPACE;
            end
        end else if (c == CH_SLASH) begin
            a.mode = MODE_SLASH;
        end else begin
            a.flush = 1'b1;
            a.sep   = SEP_NONE;
            if (c == CH_QUOTE) begin
                a.put  = 1'b1;
                a.mode = MODE_QUOTE;
            end else if (c == CH_BSL) begin
                a.mode = MODE_BSL;
            end else begin
                a.put  = 1'b1;
                a.mode = MODE_WORD;
            end
        end
        return a;
    endfunction

    function automatic t_act word_step(input t_sep s, input logic [7:0] c);
        t_act a;
        if (c <= CH_SPACE) begin
            a = tok_step(s, c);
        end else begin
            a.mode  = MODE_WORD;
            a.sep   = s;
            a.flush = 1'b0;
            a.put   = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [7:0] sep_char(input t_sep s);
        return (s == SEP_NEWLINE) ? CH_LF : CH_SPACE;
    endfunction

    // The result register can be reloaded once its last result leaves.
    assign free    = (r_idx == r_num) || ((r_idx + 2'd1 == r_num) && !i_stall);
    assign o_stall = !free;
    assign in_acc  = i_valid && free;
    assign o_valid = (r_idx != r_num);
    assign out_acc = o_valid && !i_stall;

    always_comb begin
        case (r_idx)
            2'd0:    o_out_byte = r_byte[0];
            2'd1:    o_out_byte = r_byte[1];
            2'd2:    o_out_byte = r_byte[2];
            default: o_out_byte = CH_NUL;
        endcase
        o_is_end    = r_end && (r_idx + 2'd1 == r_num);
        o_out_count = o_is_end ? r_gcnt : 16'd0;
    end

    // Next scan state and the results of the byte at the input.
    always_comb begin
        n_mode = r_mode;
        n_sep  = r_sep;
        n_end  = 1'b0;
        k      = 2'd0;
        act    = '0;
        for (int j = 0; j < RES_SLOTS; j++) begin
            n_byte[j] = CH_NUL;
        end

        if (i_in_byte == CH_NUL) begin
            if (r_mode == MODE_SLASH) begin
                if (r_sep != SEP_NONE) begin
                    n_byte[k] = sep_char(r_sep);
                    k = k + 2'd1;
                end
                n_byte[k] = CH_SLASH;
                k = k + 2'd1;
            end else if (r_mode == MODE_BSL || r_mode == MODE_BSL_CR) begin
                n_byte[k] = CH_BSL;
                k = k + 2'd1;
            end
            n_end  = 1'b1;
            n_mode = MODE_TOK;
            n_sep  = SEP_NONE;
        end else begin
            unique case (r_mode) inside
                MODE_SLASH: begin
                    if (i_in_byte == CH_SLASH) begin
                        n_sep  = SEP_SPACE;
                        n_mode = MODE_LINE;
                    end else if (i_in_byte == CH_STAR) begin
                        n_sep  = SEP_SPACE;
                        n_mode = MODE_BLOCK;
                    end else begin
                        if (n_sep != SEP_NONE) begin
                            n_byte[k] = sep_char(n_sep);
                            k = k + 2'd1;
                        end
                        n_sep = SEP_NONE;
                        n_byte[k] = CH_SLASH;
                        k = k + 2'd1;
                        act = word_step(n_sep, i_in_byte);
                    end
                end
                MODE_LINE: begin
                    if (i_in_byte == CH_LF) begin
                        act = tok_step(n_sep, i_in_byte);
                    end else begin
                        act = '{mode: MODE_LINE, sep: n_sep, flush: 1'b0, put: 1'b0};
                    end
                end
                MODE_BLOCK, MODE_BLOCK_STAR: begin
                    if (r_mode == MODE_BLOCK_STAR && i_in_byte == CH_SLASH) begin
                        n_mode = MODE_TOK;
                    end else if (i_in_byte == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;
                    end else begin
                        if (i_in_byte == CH_LF) begin
                            n_sep = SEP_NEWLINE;
                        end
                        n_mode = MODE_BLOCK;
                    end
                end
                MODE_QUOTE: begin
                    n_byte[k] = i_in_byte;
                    k = k + 2'd1;
                    if (i_in_byte == CH_QUOTE) begin
                        n_mode = MODE_TOK;
                    end
                end
                MODE_BSL: begin
                    if (i_in_byte == CH_LF) begin
                        n_mode = MODE_TOK;
                    end else if (i_in_byte == CH_CR) begin
                        n_mode = MODE_BSL_CR;
                    end else begin
                        n_byte[k] = CH_BSL;
                        k = k + 2'd1;
                        act = word_step(n_sep, i_in_byte);
                    end
                end
                MODE_BSL_CR: begin
                    if (i_in_byte == CH_LF) begin
                        n_mode = MODE_TOK;
                    end else begin
                        // The held CR becomes whitespace before this byte.
                        n_byte[k] = CH_BSL;
                        k = k + 2'd1;
                        act   = tok_step(n_sep, CH_CR);
                        n_sep = act.sep;
                        act   = tok_step(n_sep, i_in_byte);
                    end
                end
                MODE_WORD: begin
                    act = word_step(n_sep, i_in_byte);
                end
                default: begin
                    act = tok_step(n_sep, i_in_byte);
                end
            endcase

            // Apply a token-level step if one was taken above.
            if (r_mode == MODE_WORD || r_mode == MODE_LINE ||
                r_mode == MODE_TOK || r_mode > MODE_WORD ||
                (r_mode == MODE_SLASH && i_in_byte != CH_SLASH &&
                 i_in_byte != CH_STAR) ||
                (r_mode == MODE_BSL && i_in_byte != CH_LF && i_in_byte != CH_CR) ||
                (r_mode == MODE_BSL_CR && i_in_byte != CH_LF)) begin
                if (act.flush && n_sep != SEP_NONE) begin
                    n_byte[k] = sep_char(n_sep);
                    k = k + 2'd1;
                end
                if (act.put) begin
                    n_byte[k] = i_in_byte;
                    k = k + 2'd1;
                end
                n_sep  = act.sep;
                n_mode = act.mode;
            end
        end

        nb    = k;
        n_num = n_end ? k + 2'd1 : k;
        sum   = {1'b0, r_cnt} + {15'd0, nb};
        n_cnt = sum[16] ? 16'hFFFF : sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TOK;
            r_sep  <= SEP_NONE;
            r_cnt  <= 16'd0;
            r_num  <= 2'd0;
            r_idx  <= 2'd0;
            r_end  <= 1'b0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_sep  <= n_sep;
            r_cnt  <= n_end ? 16'd0 : n_cnt;
            r_num  <= n_num;
            r_idx  <= 2'd0;
            r_end  <= n_end;
        end else if (out_acc) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < RES_SLOTS; j++) begin
                r_byte[j] <= n_byte[j];
            end
            r_gcnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_num)
        else $error("result index ran past the number of results");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_byte == CH_NUL |=>
            r_mode == MODE_TOK && r_sep == SEP_NONE && r_cnt == 16'd0)
        else $error("end of string did not return the scanner to reset state");

    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end |-> o_out_byte == CH_NUL)
        else $error("end item carries a nonzero byte");

    a_text_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_end |-> o_out_count == 16'd0)
        else $error("text item carries a count");
`endif

endmodule
